### hdl/tdgs_pkg.sv
package tdgs_pkg;

	localparam int SLOT_COUNT  = 32;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
	localparam int MAX_WORKERS = 16;
	localparam int WORKER_W    = 4;
	localparam int WCNT_W      = 5;
	localparam int PATTERN_W   = 32;

	localparam int IN_DATA_W   = 40;
	localparam int OUT_DATA_W  = 16;

	typedef enum logic [2:0] {
		KIND_ADD_WAIT         = 3'd0,
		KIND_ADD_DISPATCH     = 3'd1,
		KIND_RELEASE_DISPATCH = 3'd2,
		KIND_FULL             = 3'd3,
		KIND_NOT_OCCUPIED     = 3'd4,
		KIND_NONE_RELEASED    = 3'd5
	} kind_t;

	typedef enum logic {
		CMD_ADD    = 1'b0,
		CMD_FINISH = 1'b1
	} cmd_t;

	typedef struct packed {
		logic                  en;
		logic [SLOT_W-1:0]     addr;
		logic [SLOT_COUNT-1:0] data;
	} row_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} row_rd_t;

endpackage

### hdl/tdgs_row_store.sv
module tdgs_row_store (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tdgs_pkg::row_rd_t               rd,
	input  tdgs_pkg::row_wr_t               wr,
	output logic [tdgs_pkg::SLOT_COUNT-1:0] rd_row
);

	logic [tdgs_pkg::SLOT_COUNT-1:0] mem [tdgs_pkg::SLOT_COUNT];
	logic [tdgs_pkg::SLOT_COUNT-1:0] rdata_q;
	logic [tdgs_pkg::SLOT_COUNT-1:0] row_valid_q;
	logic                            rvalid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_q <= mem[rd.addr];
		end
	end

	// A row never written since reset reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
		end else begin
			if (wr.en) begin
				row_valid_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rvalid_q <= row_valid_q[rd.addr];
			end
		end
	end

	assign rd_row = rvalid_q ? rdata_q : '0;

endmodule

### hdl/tdgs_rr.sv
module tdgs_rr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tdgs_pkg::WCNT_W-1:0]   cfg_wdata,
	input  logic                          adv,
	output logic [tdgs_pkg::WORKER_W-1:0] worker,
	output logic                          ready
);

	logic [tdgs_pkg::WCNT_W-1:0]   wcount_q;
	logic [tdgs_pkg::WORKER_W-1:0] rr_q;
	logic [tdgs_pkg::WCNT_W-1:0]   n_eff;
	logic [tdgs_pkg::WCNT_W-1:0]   rr_ext;
	logic [tdgs_pkg::WCNT_W-1:0]   inc;
	logic [tdgs_pkg::WCNT_W-1:0]   reduced;

	always_comb begin
		if (wcount_q == '0) begin
			n_eff = tdgs_pkg::WCNT_W'(1);
		end else if (wcount_q > tdgs_pkg::WCNT_W'(tdgs_pkg::MAX_WORKERS)) begin
			n_eff = tdgs_pkg::WCNT_W'(tdgs_pkg::MAX_WORKERS);
		end else begin
			n_eff = wcount_q;
		end
	end

	assign rr_ext  = tdgs_pkg::WCNT_W'(rr_q);
	assign inc     = rr_ext + tdgs_pkg::WCNT_W'(1);
	assign reduced = rr_ext - n_eff;
	assign ready   = rr_ext < n_eff;
	assign worker  = (inc == n_eff) ? '0 : inc[tdgs_pkg::WORKER_W-1:0];

	// After a change of the worker count the pointer is brought back into range
	// by one subtraction per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcount_q <= tdgs_pkg::WCNT_W'(1);
			rr_q     <= '0;
		end else begin
			if (cfg_we) begin
				wcount_q <= cfg_wdata;
			end
			if (!ready) begin
				rr_q <= reduced[tdgs_pkg::WORKER_W-1:0];
			end else if (adv) begin
				rr_q <= worker;
			end
		end
	end

endmodule

### hdl/task_dependence_graph_scheduler.sv
// Channel   Direction  Item
// s_*       in         tuser: command; tdata: dep_pattern, finished_slot
// m_*       out        tuser: kind; tdata: slot, worker; tlast: last
// cfg_*     in         worker_count, one register, write only
//
// An add or a rejected finish gives one item.
// An accepted finish sweeps the dependence memory one row per cycle, unless the
// output stalls it, through its single read port and write port.
// A stalled output holds the sweep only when a second release is found.
// After a worker count write the pointer settles back into range while s_tready is low.
// Reset is asynchronous; the table comes up empty with all slots free.
module task_dependence_graph_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [tdgs_pkg::IN_DATA_W-1:0]    s_tdata,   // dep_pattern[31:0], finished_slot[36:32]
	input  logic                              s_tuser,   // command
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [tdgs_pkg::OUT_DATA_W-1:0]   m_tdata,   // slot[4:0], worker[8:5]
	output logic [2:0]                        m_tuser,   // kind
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [tdgs_pkg::WCNT_W-1:0]       cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_LAST
	} state_t;

	state_t                                state_q;
	logic                                  out_valid_q;
	tdgs_pkg::kind_t                       out_kind_q;
	logic [tdgs_pkg::SLOT_W-1:0]           out_slot_q;
	logic [tdgs_pkg::WORKER_W-1:0]         out_worker_q;
	logic                                  out_last_q;

	logic [tdgs_pkg::SLOT_COUNT-1:0]       occ_q;
	logic [tdgs_pkg::CNT_W-1:0]            free_cnt_q;
	logic [tdgs_pkg::SLOT_W-1:0]           free_stack_q [tdgs_pkg::SLOT_COUNT];
	logic [tdgs_pkg::SLOT_W-1:0]           fslot_q;
	logic [tdgs_pkg::CNT_W-1:0]            rd_idx_q;
	logic                                  valid_s1;
	logic [tdgs_pkg::SLOT_W-1:0]           idx_s1;
	logic                                  pend_q;
	logic [tdgs_pkg::SLOT_W-1:0]           pend_slot_q;

	tdgs_pkg::cmd_t                        in_cmd;
	logic [tdgs_pkg::PATTERN_W-1:0]        in_pattern;
	logic [tdgs_pkg::SLOT_W-1:0]           in_slot;
	logic                                  out_free;
	logic                                  accept;
	logic                                  full;
	logic                                  occ_hit;
	logic [tdgs_pkg::SLOT_W-1:0]           pop_slot;
	logic [tdgs_pkg::SLOT_COUNT-1:0]       keep;
	logic [tdgs_pkg::SLOT_COUNT-1:0]       rd_row;
	logic [tdgs_pkg::SLOT_COUNT-1:0]       prev_row;
	logic [tdgs_pkg::SLOT_COUNT-1:0]       new_row;
	logic                                  release_hit;
	logic                                  sweep_go;
	logic                                  sweep_end;
	logic                                  add_ok;
	logic                                  rr_adv;
	logic                                  rr_ready;
	logic [tdgs_pkg::WORKER_W-1:0]         rr_worker;
	tdgs_pkg::row_rd_t                     row_rd;
	tdgs_pkg::row_wr_t                     row_wr;

	assign in_cmd     = tdgs_pkg::cmd_t'(s_tuser);
	assign in_pattern = s_tdata[tdgs_pkg::PATTERN_W-1:0];
	assign in_slot    = s_tdata[tdgs_pkg::PATTERN_W +: tdgs_pkg::SLOT_W];

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free && rr_ready;
	assign accept   = s_tvalid && s_tready;

	assign full     = (free_cnt_q == '0);
	assign pop_slot = free_stack_q[tdgs_pkg::SLOT_W'(free_cnt_q - tdgs_pkg::CNT_W'(1))];
	assign occ_hit  = occ_q[in_slot];
	assign add_ok   = accept && (in_cmd == tdgs_pkg::CMD_ADD) && !full;

	assign keep     = ~(tdgs_pkg::SLOT_COUNT'(1) << fslot_q);
	assign prev_row = (idx_s1 == fslot_q) ? '0 : rd_row;
	assign new_row  = prev_row & keep;
	assign release_hit = valid_s1 && (prev_row != '0) && (new_row == '0);

	assign sweep_go  = (state_q == ST_SWEEP) && !(release_hit && pend_q && !out_free);
	assign sweep_end = (rd_idx_q == tdgs_pkg::CNT_W'(tdgs_pkg::SLOT_COUNT));

	assign row_rd.en   = sweep_go && !sweep_end;
	assign row_rd.addr = rd_idx_q[tdgs_pkg::SLOT_W-1:0];

	always_comb begin
		row_wr.en   = 1'b0;
		row_wr.addr = idx_s1;
		row_wr.data = new_row;
		if (add_ok) begin
			row_wr.en   = 1'b1;
			row_wr.addr = pop_slot;
			row_wr.data = in_pattern[tdgs_pkg::SLOT_COUNT-1:0];
		end else if (sweep_go && valid_s1) begin
			row_wr.en = 1'b1;
		end
	end

	assign rr_adv = (add_ok && (in_pattern == '0))
		|| (sweep_go && release_hit && pend_q)
		|| ((state_q == ST_LAST) && out_free && pend_q);

	tdgs_row_store u_rows (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (row_rd),
		.wr     (row_wr),
		.rd_row (rd_row)
	);

	tdgs_rr u_rr (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.adv       (rr_adv),
		.worker    (rr_worker),
		.ready     (rr_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tdgs_pkg::SLOT_COUNT; i++) begin
				free_stack_q[i] <= tdgs_pkg::SLOT_W'(i);
			end
		end else if (accept && (in_cmd == tdgs_pkg::CMD_FINISH) && occ_hit) begin
			free_stack_q[free_cnt_q[tdgs_pkg::SLOT_W-1:0]] <= in_slot;
		end
	end

	// A release is held back until the next one is found or the sweep ends,
	// so that the final one can carry tlast.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			out_kind_q   <= tdgs_pkg::KIND_ADD_WAIT;
			out_slot_q   <= '0;
			out_worker_q <= '0;
			out_last_q   <= 1'b0;
			occ_q        <= '0;
			free_cnt_q   <= tdgs_pkg::CNT_W'(tdgs_pkg::SLOT_COUNT);
			fslot_q      <= '0;
			rd_idx_q     <= '0;
			valid_s1     <= 1'b0;
			idx_s1       <= '0;
			pend_q       <= 1'b0;
			pend_slot_q  <= '0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						if (in_cmd == tdgs_pkg::CMD_ADD) begin
							if (full) begin
								out_kind_q   <= tdgs_pkg::KIND_FULL;
								out_slot_q   <= '0;
								out_worker_q <= '0;
							end else begin
								free_cnt_q      <= free_cnt_q - tdgs_pkg::CNT_W'(1);
								occ_q[pop_slot] <= 1'b1;
								out_slot_q      <= pop_slot;
								if (in_pattern == '0) begin
									out_kind_q   <= tdgs_pkg::KIND_ADD_DISPATCH;
									out_worker_q <= rr_worker;
								end else begin
									out_kind_q   <= tdgs_pkg::KIND_ADD_WAIT;
									out_worker_q <= '0;
								end
							end
						end else if (!occ_hit) begin
							out_kind_q   <= tdgs_pkg::KIND_NOT_OCCUPIED;
							out_slot_q   <= in_slot;
							out_worker_q <= '0;
						end else begin
							out_valid_q    <= m_tready ? 1'b0 : out_valid_q;
							occ_q[in_slot] <= 1'b0;
							free_cnt_q     <= free_cnt_q + tdgs_pkg::CNT_W'(1);
							fslot_q        <= in_slot;
							rd_idx_q       <= '0;
							valid_s1       <= 1'b0;
							pend_q         <= 1'b0;
							state_q        <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					if (sweep_go) begin
						if (row_rd.en) begin
							rd_idx_q <= rd_idx_q + tdgs_pkg::CNT_W'(1);
							valid_s1 <= 1'b1;
							idx_s1   <= rd_idx_q[tdgs_pkg::SLOT_W-1:0];
						end else begin
							valid_s1 <= 1'b0;
						end
						if (release_hit) begin
							if (pend_q) begin
								out_valid_q  <= 1'b1;
								out_kind_q   <= tdgs_pkg::KIND_RELEASE_DISPATCH;
								out_slot_q   <= pend_slot_q;
								out_worker_q <= rr_worker;
								out_last_q   <= 1'b0;
							end
							pend_q      <= 1'b1;
							pend_slot_q <= idx_s1;
						end
						if (!valid_s1 && sweep_end) begin
							state_q <= ST_LAST;
						end
					end
				end
				ST_LAST: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_last_q  <= 1'b1;
						if (pend_q) begin
							out_kind_q   <= tdgs_pkg::KIND_RELEASE_DISPATCH;
							out_slot_q   <= pend_slot_q;
							out_worker_q <= rr_worker;
						end else begin
							out_kind_q   <= tdgs_pkg::KIND_NONE_RELEASED;
							out_slot_q   <= fslot_q;
							out_worker_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {
		(tdgs_pkg::OUT_DATA_W - tdgs_pkg::SLOT_W - tdgs_pkg::WORKER_W)'(0),
		out_worker_q,
		out_slot_q
	};

endmodule

### hdl/tdgs_checker.sv
module tdgs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [tdgs_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic [2:0]                      m_tuser,
	input logic                            m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("Output item dropped while stalled.");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
		else $error("Output item changed while stalled.");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != tdgs_pkg::KIND_RELEASE_DISPATCH) |-> m_tlast)
		else $error("Single-result item without tlast.");

	a_no_worker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != tdgs_pkg::KIND_RELEASE_DISPATCH)
			&& (m_tuser != tdgs_pkg::KIND_ADD_DISPATCH)
		|-> (m_tdata[8:5] == 4'd0))
		else $error("Worker set on an item without dispatch.");

	a_full_slot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == tdgs_pkg::KIND_FULL) |-> (m_tdata[4:0] == 5'd0))
		else $error("Full-table item carries a slot.");

endmodule

bind task_dependence_graph_scheduler tdgs_checker u_tdgs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
